>>> hdl/pct_pkg.sv
package pct_pkg;

  localparam int CURSOR_W = 16;
  localparam int LIMIT_W  = 16;
  localparam int BYTE_W   = 8;
  localparam int BTN_W    = 3;
  localparam int DELTA_W  = 10;
  localparam int CFG_IDX_W = 1;

  // operation codes
  localparam logic OP_BYTE     = 1'b0;
  localparam logic OP_SNAPSHOT = 1'b1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_X_LIMIT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_Y_LIMIT = 1'd1;

  localparam logic [LIMIT_W-1:0] X_LIMIT_RESET = 16'd1023;
  localparam logic [LIMIT_W-1:0] Y_LIMIT_RESET = 16'd767;
  localparam int POS_X_RESET = 512;
  localparam int POS_Y_RESET = 384;

  // header byte layout
  localparam int HDR_SYNC_BIT  = 3;
  localparam int HDR_XSIGN_BIT = 4;
  localparam int HDR_YSIGN_BIT = 5;
  localparam int BTN_LEFT      = 0;
  localparam int BTN_RIGHT     = 1;

  typedef struct packed {
    logic              operation;
    logic [BYTE_W-1:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [CURSOR_W-1:0] cursor_x;
    logic [CURSOR_W-1:0] cursor_y;
    logic [BTN_W-1:0]    live_buttons;
    logic                left_held;
    logic                left_click;
    logic                right_click;
    logic                packet_done;
  } out_item_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0] reg_index;
    logic [LIMIT_W-1:0]   wdata;
  } cfg_item_t;

  // per-axis move request from the packet decoder
  typedef struct packed {
    logic                      step;
    logic                      move;
    logic signed [DELTA_W-1:0] delta;
  } axis_cmd_t;

  // button fields of the result after this beat
  typedef struct packed {
    logic [BTN_W-1:0] live_buttons;
    logic             left_held;
    logic             left_click;
    logic             right_click;
    logic             packet_done;
  } btn_status_t;

endpackage

>>> hdl/pct_stream_if.sv
interface pct_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

>>> hdl/pct_cfg_regs.sv
module pct_cfg_regs (
  input  logic                       clk,
  input  logic                       rst,
  pct_stream_if.sink                 cfg,
  output logic [pct_pkg::LIMIT_W-1:0] x_limit,
  output logic [pct_pkg::LIMIT_W-1:0] y_limit
);
  import pct_pkg::*;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      x_limit <= X_LIMIT_RESET;
      y_limit <= Y_LIMIT_RESET;
    end else if (cfg.valid) begin
      case (cfg.payload.reg_index)
        REG_X_LIMIT: x_limit <= cfg.payload.wdata;
        REG_Y_LIMIT: y_limit <= cfg.payload.wdata;
        default: ;
      endcase
    end
  end

endmodule

>>> hdl/pct_decoder.sv
module pct_decoder (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  pct_pkg::in_item_t   item,
  output pct_pkg::axis_cmd_t  x_cmd,
  output pct_pkg::axis_cmd_t  y_cmd,
  output pct_pkg::btn_status_t status_next
);
  import pct_pkg::*;

  localparam logic [1:0] PH_HEADER = 2'd0;
  localparam logic [1:0] PH_XDELTA = 2'd1;
  localparam logic [1:0] PH_YDELTA = 2'd2;

  logic [1:0]        byte_phase, byte_phase_next;
  logic [BYTE_W-1:0] header_hold, header_hold_next;
  logic [BYTE_W-1:0] xdelta_hold, xdelta_hold_next;
  logic [BTN_W-1:0]  buttons_latest, buttons_latest_next;
  logic [BTN_W-1:0]  buttons_snapshot, buttons_snapshot_next;
  logic [BTN_W-1:0]  buttons_previous, buttons_previous_next;
  logic              move;
  logic              done;
  logic signed [DELTA_W-1:0] dx;
  logic signed [DELTA_W-1:0] dy;

  always_comb begin
    byte_phase_next       = byte_phase;
    header_hold_next      = header_hold;
    xdelta_hold_next      = xdelta_hold;
    buttons_latest_next   = buttons_latest;
    buttons_snapshot_next = buttons_snapshot;
    buttons_previous_next = buttons_previous;
    move = 1'b0;
    done = 1'b0;
    if (item.operation == OP_SNAPSHOT) begin
      buttons_previous_next = buttons_snapshot;
      buttons_snapshot_next = buttons_latest;
    end else begin
      case (byte_phase)
        PH_XDELTA: begin
          xdelta_hold_next = item.data_byte;
          byte_phase_next  = PH_YDELTA;
        end
        PH_YDELTA: begin
          buttons_latest_next = header_hold[BTN_W-1:0];
          byte_phase_next     = PH_HEADER;
          move = 1'b1;
          done = 1'b1;
        end
        default: begin
          // a header must carry the sync bit, else the byte is dropped
          if (item.data_byte[HDR_SYNC_BIT]) begin
            header_hold_next = item.data_byte;
            byte_phase_next  = PH_XDELTA;
          end else begin
            byte_phase_next = PH_HEADER;
          end
        end
      endcase
    end
  end

  // 9-bit signed deltas, sign from the header
  assign dx = {header_hold[HDR_XSIGN_BIT], header_hold[HDR_XSIGN_BIT], xdelta_hold};
  assign dy = {header_hold[HDR_YSIGN_BIT], header_hold[HDR_YSIGN_BIT], item.data_byte};

  assign x_cmd.step  = step;
  assign x_cmd.move  = move;
  assign x_cmd.delta = dx;
  assign y_cmd.step  = step;
  assign y_cmd.move  = move;
  assign y_cmd.delta = -dy;  // screen y grows downward

  assign status_next.live_buttons = buttons_latest_next;
  assign status_next.left_held    = buttons_snapshot_next[BTN_LEFT];
  assign status_next.left_click   = buttons_snapshot_next[BTN_LEFT] &
                                    ~buttons_previous_next[BTN_LEFT];
  assign status_next.right_click  = buttons_snapshot_next[BTN_RIGHT] &
                                    ~buttons_previous_next[BTN_RIGHT];
  assign status_next.packet_done  = done;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_phase       <= PH_HEADER;
      header_hold      <= '0;
      xdelta_hold      <= '0;
      buttons_latest   <= '0;
      buttons_snapshot <= '0;
      buttons_previous <= '0;
    end else if (step) begin
      byte_phase       <= byte_phase_next;
      header_hold      <= header_hold_next;
      xdelta_hold      <= xdelta_hold_next;
      buttons_latest   <= buttons_latest_next;
      buttons_snapshot <= buttons_snapshot_next;
      buttons_previous <= buttons_previous_next;
    end
  end

endmodule

>>> hdl/pct_axis.sv
module pct_axis #(
  parameter int POS_WIDTH = 16,
  parameter int RESET_POS = 0
) (
  input  logic                       clk,
  input  logic                       rst,
  input  pct_pkg::axis_cmd_t         cmd,
  input  logic [pct_pkg::LIMIT_W-1:0] limit,
  output logic [POS_WIDTH-1:0]       pos_next
);
  import pct_pkg::*;

  localparam int EW = (POS_WIDTH > LIMIT_W) ? POS_WIDTH : LIMIT_W;
  localparam int SW = POS_WIDTH + 2;

  logic [EW-1:0]        lim_ext;
  logic [EW-1:0]        pos_cap;
  logic [EW-1:0]        eff_ext;
  logic [POS_WIDTH-1:0] eff;
  logic [POS_WIDTH-1:0] pos;
  logic [POS_WIDTH-1:0] pos_clamped;
  logic [POS_WIDTH-1:0] moved;
  logic signed [SW-1:0] sum;

  // limit is also capped by the position range
  assign lim_ext = EW'(limit);
  assign pos_cap = EW'({POS_WIDTH{1'b1}});
  assign eff_ext = (lim_ext > pos_cap) ? pos_cap : lim_ext;
  assign eff     = eff_ext[POS_WIDTH-1:0];

  // stored position follows any bound change before the move
  assign pos_clamped = (pos > eff) ? eff : pos;

  assign sum = $signed({2'b00, pos_clamped}) + SW'(cmd.delta);

  always_comb begin
    if (sum < 0) begin
      moved = '0;
    end else if (sum > $signed({2'b00, eff})) begin
      moved = eff;
    end else begin
      moved = sum[POS_WIDTH-1:0];
    end
  end

  assign pos_next = cmd.move ? moved : pos_clamped;

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= POS_WIDTH'(RESET_POS);
    end else if (cmd.step) begin
      pos <= pos_next;
    end
  end

endmodule

>>> hdl/pointer_packet_cursor_tracker_top.sv
// pointer packet cursor tracker
//
// pkt_in carries one beat per device byte (operation = byte) or per frame
// snapshot (operation = snapshot). header, x delta and y delta bytes build
// a packet; a header is taken only with its sync bit set. each accepted
// beat yields exactly one result beat on res_out with the cursor position,
// the live buttons, the snapshot click flags and packet_done.
// cfg writes the x and y limit registers; ready is always high and writes
// are expected only while the block is idle.
//
// each accepted beat's result is registered in the output register.
// throughput: one beat per cycle while res_out does not stall, set by
// the single result register; all decode and clamp logic sits in front
// of it. a stall on res_out holds the result; pkt_in stays ready while
// the output register is empty or being drained in the same cycle.
// reset (rst, synchronous) drops any pending result, returns the decoder to
// waiting for a header, clears the buttons, puts the cursor at 512/384 and
// the limits at 1023/767.
module pointer_packet_cursor_tracker_top #(
  parameter int POS_WIDTH = 16
) (
  input logic        clk,
  input logic        rst,
  pct_stream_if.sink   pkt_in,
  pct_stream_if.source res_out,
  pct_stream_if.sink   cfg
);
  import pct_pkg::*;

  logic [LIMIT_W-1:0]   x_limit;
  logic [LIMIT_W-1:0]   y_limit;
  logic                 accept;
  axis_cmd_t            x_cmd;
  axis_cmd_t            y_cmd;
  btn_status_t          status_next;
  logic [POS_WIDTH-1:0] x_next;
  logic [POS_WIDTH-1:0] y_next;
  logic                 out_valid;
  out_item_t            out_item;

  // a new beat enters whenever the result register frees up this cycle
  assign pkt_in.ready = ~out_valid | res_out.ready;
  assign accept       = pkt_in.valid & pkt_in.ready;

  pct_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .x_limit (x_limit),
    .y_limit (y_limit)
  );

  // packet framing and button history
  pct_decoder u_dec (
    .clk         (clk),
    .rst         (rst),
    .step        (accept),
    .item        (pkt_in.payload),
    .x_cmd       (x_cmd),
    .y_cmd       (y_cmd),
    .status_next (status_next)
  );

  // per-axis bound clamp and saturating move
  pct_axis #(
    .POS_WIDTH (POS_WIDTH),
    .RESET_POS (POS_X_RESET)
  ) u_axis_x (
    .clk      (clk),
    .rst      (rst),
    .cmd      (x_cmd),
    .limit    (x_limit),
    .pos_next (x_next)
  );

  pct_axis #(
    .POS_WIDTH (POS_WIDTH),
    .RESET_POS (POS_Y_RESET)
  ) u_axis_y (
    .clk      (clk),
    .rst      (rst),
    .cmd      (y_cmd),
    .limit    (y_limit),
    .pos_next (y_next)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (res_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_item.cursor_x     <= CURSOR_W'(x_next);
      out_item.cursor_y     <= CURSOR_W'(y_next);
      out_item.live_buttons <= status_next.live_buttons;
      out_item.left_held    <= status_next.left_held;
      out_item.left_click   <= status_next.left_click;
      out_item.right_click  <= status_next.right_click;
      out_item.packet_done  <= status_next.packet_done;
    end
  end

  assign res_out.valid   = out_valid;
  assign res_out.payload = out_item;

  // every accepted beat has its result waiting in the next cycle
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    accept |=> out_valid)
    else $error("accepted beat produced no result");

  // a snapshot never completes a packet
  a_snapshot_no_done: assert property (@(posedge clk) disable iff (rst)
    accept && pkt_in.payload.operation == OP_SNAPSHOT |=> !out_item.packet_done)
    else $error("snapshot flagged packet_done");

  // a left click is always a held left button in the current snapshot
  a_click_held: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (!out_item.left_click || out_item.left_held))
    else $error("left click without left held");

  // the reported cursor never exceeds its bounds
  a_cursor_bounded: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_item.cursor_x <= x_limit && out_item.cursor_y <= y_limit))
    else $error("cursor beyond limit");

endmodule

>>> tb/tb_pointer_packet_cursor_tracker_top.sv
module tb_pointer_packet_cursor_tracker_top;
  timeunit 1ns;
  timeprecision 1ps;

  import pct_pkg::*;

  // decoder position inside a three-byte packet
  typedef enum logic [1:0] {
    WAIT_HDR,
    WAIT_DX,
    WAIT_DY
  } pkt_phase_e;

  // one directed row: stimulus, and a literal result where it is obvious
  typedef struct packed {
    logic              op;
    logic [BYTE_W-1:0] data;
    logic              fixed;
    out_item_t         lit;
  } dir_row_t;

  localparam int NUM_DIR     = 25;
  localparam int NUM_PHASES  = 8;
  localparam int PHASE_ITEMS = 65;
  localparam int DRAIN_CYC   = 3;   // settling margin after the last owed result
  localparam int HOLD_CYC    = 80;  // long receiver hold-off

  // cursor at its reset position, nothing pressed
  localparam out_item_t AT_HOME = '{16'd512, 16'd384, 3'd0, 1'b0, 1'b0, 1'b0, 1'b0};

  // directed walk, starting right after reset (limits 1023/767)
  localparam dir_row_t DIR_TAB [NUM_DIR] = '{
    // snapshot with nothing pressed
    '{OP_SNAPSHOT, 8'h00, 1'b1, AT_HOME},
    // headers without the sync bit are dropped
    '{OP_BYTE, 8'h00, 1'b1, AT_HOME},
    '{OP_BYTE, 8'hF7, 1'b1, AT_HOME},
    // all buttons, largest positive x, zero y
    '{OP_BYTE, 8'h0F, 1'b1, AT_HOME},
    '{OP_BYTE, 8'hFF, 1'b1, AT_HOME},
    '{OP_BYTE, 8'h00, 1'b1, '{16'd767, 16'd384, 3'd7, 1'b0, 1'b0, 1'b0, 1'b1}},
    // first snapshot sees both clicks, second sees none
    '{OP_SNAPSHOT, 8'hFF, 1'b1, '{16'd767, 16'd384, 3'd7, 1'b1, 1'b1, 1'b1, 1'b0}},
    '{OP_SNAPSHOT, 8'h5A, 1'b1, '{16'd767, 16'd384, 3'd7, 1'b1, 1'b0, 1'b0, 1'b0}},
    // most negative deltas on both axes
    '{OP_BYTE, 8'h38, 1'b0, '0},
    '{OP_BYTE, 8'h00, 1'b0, '0},
    '{OP_BYTE, 8'h00, 1'b0, '0},
    // left only, positive deltas
    '{OP_BYTE, 8'h09, 1'b0, '0},
    '{OP_BYTE, 8'hFF, 1'b0, '0},
    '{OP_BYTE, 8'hFF, 1'b0, '0},
    // snapshot in the middle of a packet
    '{OP_BYTE, 8'h3A, 1'b0, '0},
    '{OP_SNAPSHOT, 8'h00, 1'b0, '0},
    '{OP_BYTE, 8'h01, 1'b0, '0},
    '{OP_BYTE, 8'h01, 1'b0, '0},
    '{OP_SNAPSHOT, 8'h00, 1'b0, '0},
    // y pushed past its limit
    '{OP_BYTE, 8'hFF, 1'b0, '0},
    '{OP_BYTE, 8'h00, 1'b0, '0},
    '{OP_BYTE, 8'h00, 1'b0, '0},
    // x pushed below zero
    '{OP_BYTE, 8'h18, 1'b0, '0},
    '{OP_BYTE, 8'h00, 1'b0, '0},
    '{OP_BYTE, 8'h00, 1'b0, '0}
  };

  logic clk;
  logic rst;

  pct_stream_if #(.payload_t(in_item_t))  pkt_if ();
  pct_stream_if #(.payload_t(out_item_t)) res_if ();
  pct_stream_if #(.payload_t(cfg_item_t)) cfg_if ();

  pointer_packet_cursor_tracker_top #(.POS_WIDTH(16)) i_dut (
    .clk     (clk),
    .rst     (rst),
    .pkt_in  (pkt_if),
    .res_out (res_if),
    .cfg     (cfg_if)
  );

  // tracker state mirrored by the predictor
  pkt_phase_e          rx_phase  = WAIT_HDR;
  logic [BYTE_W-1:0]   hdr_byte  = '0;
  logic [BYTE_W-1:0]   dx_byte   = '0;
  logic [CURSOR_W-1:0] cur_x     = CURSOR_W'(POS_X_RESET);
  logic [CURSOR_W-1:0] cur_y     = CURSOR_W'(POS_Y_RESET);
  logic [BTN_W-1:0]    btn_live  = '0;
  logic [BTN_W-1:0]    frame_btn = '0;
  logic [BTN_W-1:0]    prior_btn = '0;
  logic [LIMIT_W-1:0]  x_lim     = X_LIMIT_RESET;
  logic [LIMIT_W-1:0]  y_lim     = Y_LIMIT_RESET;

  out_item_t cursor_exp_q [$];   // results still owed by the block
  in_item_t  byte_q [$];         // random beats of the current phase

  int errors         = 0;
  int src_idle_pct   = 0;
  int sink_stall_pct = 0;
  int hold_left      = 0;

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // advance the tracker by one beat and return the result it owes
  function automatic out_item_t track_cursor(in_item_t it);
    int dx;
    int dy;
    int vx;
    int vy;
    out_item_t r;
    // stored position follows a lowered limit before anything else
    if (cur_x > x_lim) cur_x = x_lim;
    if (cur_y > y_lim) cur_y = y_lim;
    r.packet_done = 1'b0;
    if (it.operation == OP_SNAPSHOT) begin
      prior_btn = frame_btn;
      frame_btn = btn_live;
    end else begin
      case (rx_phase)
        WAIT_DX: begin
          dx_byte  = it.data_byte;
          rx_phase = WAIT_DY;
        end
        WAIT_DY: begin
          // 9-bit deltas, sign bits live in the header
          dx = int'(dx_byte);
          dy = int'(it.data_byte);
          if (hdr_byte[HDR_XSIGN_BIT]) dx -= 256;
          if (hdr_byte[HDR_YSIGN_BIT]) dy -= 256;
          btn_live = hdr_byte[BTN_W-1:0];
          vx = int'(cur_x) + dx;
          vy = int'(cur_y) - dy;   // screen y grows downward
          if (vx < 0) vx = 0;
          if (vy < 0) vy = 0;
          if (vx > int'(x_lim)) vx = int'(x_lim);
          if (vy > int'(y_lim)) vy = int'(y_lim);
          cur_x = CURSOR_W'(vx);
          cur_y = CURSOR_W'(vy);
          rx_phase      = WAIT_HDR;
          r.packet_done = 1'b1;
        end
        default: begin
          // only a byte with the sync bit starts a packet
          if (it.data_byte[HDR_SYNC_BIT]) begin
            hdr_byte = it.data_byte;
            rx_phase = WAIT_DX;
          end else begin
            rx_phase = WAIT_HDR;
          end
        end
      endcase
    end
    r.cursor_x     = cur_x;
    r.cursor_y     = cur_y;
    r.live_buttons = btn_live;
    r.left_held    = frame_btn[BTN_LEFT];
    r.left_click   = frame_btn[BTN_LEFT] & ~prior_btn[BTN_LEFT];
    r.right_click  = frame_btn[BTN_RIGHT] & ~prior_btn[BTN_RIGHT];
    return r;
  endfunction

  function automatic void chk_field(string name, int want, int got);
    if (want != got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endfunction

  // compare one result beat against the oldest owed result
  task automatic check_result(input out_item_t got);
    out_item_t want;
    if (cursor_exp_q.size() == 0) begin
      errors++;
      $display("%0t: result beat with none owed, expected nothing, actual x=%0d y=%0d",
               $time, got.cursor_x, got.cursor_y);
      return;
    end
    want = cursor_exp_q.pop_front();
    chk_field("cursor_x",     want.cursor_x,     got.cursor_x);
    chk_field("cursor_y",     want.cursor_y,     got.cursor_y);
    chk_field("live_buttons", want.live_buttons, got.live_buttons);
    chk_field("left_held",    want.left_held,    got.left_held);
    chk_field("left_click",   want.left_click,   got.left_click);
    chk_field("right_click",  want.right_click,  got.right_click);
    chk_field("packet_done",  want.packet_done,  got.packet_done);
  endtask

  // receiver: random stalls, plus a long hold-off when asked for
  initial begin
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && res_if.valid && res_if.ready) check_result(res_if.payload);
      if (hold_left > 0) begin
        res_if.ready <= 1'b0;
        hold_left--;
      end else begin
        res_if.ready <= ($urandom_range(99) >= sink_stall_pct);
      end
    end
  end

  // offer one beat, with random idle cycles ahead of it; valid stays high
  // on return so back-to-back beats need no extra assignment
  task automatic send_item(input in_item_t it, input logic fixed, input out_item_t lit);
    out_item_t pred;
    while ($urandom_range(99) < src_idle_pct) begin
      pkt_if.valid <= 1'b0;
      @(posedge clk);
    end
    pkt_if.valid   <= 1'b1;
    pkt_if.payload <= it;
    do @(posedge clk); while (!pkt_if.ready);
    pred = track_cursor(it);
    cursor_exp_q.push_back(fixed ? lit : pred);
  endtask

  // wait until every owed result has come, then let the pipeline settle
  task automatic drain_results();
    while (cursor_exp_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
  endtask

  // write both limits; valid stays high across the two beats
  task automatic set_limits(input logic [LIMIT_W-1:0] lx, input logic [LIMIT_W-1:0] ly);
    cfg_if.valid   <= 1'b1;
    cfg_if.payload <= '{reg_index: REG_X_LIMIT, wdata: lx};
    do @(posedge clk); while (!cfg_if.ready);
    x_lim = lx;
    cfg_if.payload <= '{reg_index: REG_Y_LIMIT, wdata: ly};
    do @(posedge clk); while (!cfg_if.ready);
    y_lim = ly;
    cfg_if.valid <= 1'b0;
  endtask

  // mostly whole packets with random content, some snapshots and noise
  task automatic build_items(input int n);
    in_item_t it;
    int r;
    while (byte_q.size() < n) begin
      r = $urandom_range(99);
      it.operation = OP_BYTE;
      if (r < 70) begin
        it.data_byte = BYTE_W'($urandom_range(255)) | BYTE_W'(1 << HDR_SYNC_BIT);
        byte_q.push_back(it);
        if ($urandom_range(9) == 0) begin
          // snapshot landing inside a packet
          it.operation = OP_SNAPSHOT;
          it.data_byte = BYTE_W'($urandom_range(255));
          byte_q.push_back(it);
          it.operation = OP_BYTE;
        end
        it.data_byte = BYTE_W'($urandom_range(255));
        byte_q.push_back(it);
        it.data_byte = BYTE_W'($urandom_range(255));
        byte_q.push_back(it);
      end else if (r < 85) begin
        it.operation = OP_SNAPSHOT;
        it.data_byte = BYTE_W'($urandom_range(255));
        byte_q.push_back(it);
      end else if (r < 93) begin
        // header candidate without sync, dropped
        it.data_byte = BYTE_W'($urandom_range(255)) & ~BYTE_W'(1 << HDR_SYNC_BIT);
        byte_q.push_back(it);
      end else begin
        // any byte, may knock the packet alignment off
        it.data_byte = BYTE_W'($urandom_range(255));
        byte_q.push_back(it);
      end
    end
  endtask

  // main sequence
  initial begin
    in_item_t it;
    logic [LIMIT_W-1:0] lx;
    logic [LIMIT_W-1:0] ly;
    int n;
    rst            <= 1'b1;
    pkt_if.valid   <= 1'b0;
    pkt_if.payload <= '0;
    cfg_if.valid   <= 1'b0;
    cfg_if.payload <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed walk at reset limits, no idling
    for (int i = 0; i < NUM_DIR; i++) begin
      it.operation = DIR_TAB[i].op;
      it.data_byte = DIR_TAB[i].data;
      send_item(it, DIR_TAB[i].fixed, DIR_TAB[i].lit);
    end
    pkt_if.valid <= 1'b0;

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      drain_results();

      // limit settings, extremes among them; lowering a limit below the
      // cursor exercises the clamp on the next beat
      case (ph)
        0: begin lx = 16'd100;   ly = 16'd50;    end
        1: begin lx = '0;        ly = '0;        end
        2: begin lx = '1;        ly = '1;        end
        3: begin lx = 16'd1023;  ly = 16'd767;   end
        4: begin
          lx = LIMIT_W'($urandom_range(65535));
          ly = LIMIT_W'($urandom_range(65535));
        end
        5: begin lx = 16'd1;     ly = '1;        end
        6: begin lx = '1;        ly = '0;        end
        default: begin
          lx = LIMIT_W'($urandom_range(600));
          ly = LIMIT_W'($urandom_range(600));
        end
      endcase
      set_limits(lx, ly);

      // idling mode: none, sender, receiver, both
      case (ph % 4)
        0:       begin src_idle_pct = 0;  sink_stall_pct = 0;  end
        1:       begin src_idle_pct = 58; sink_stall_pct = 0;  end
        2:       begin src_idle_pct = 0;  sink_stall_pct = 58; end
        default: begin src_idle_pct = 30; sink_stall_pct = 30; end
      endcase

      build_items(PHASE_ITEMS);
      // long receiver hold-off while the sender keeps pushing
      if (ph == 2 || ph == 5) hold_left = HOLD_CYC;
      n = byte_q.size();
      for (int k = 0; k < n; k++) begin
        if (k == n / 2) begin
          // sender pause until the block has handed back everything
          pkt_if.valid <= 1'b0;
          drain_results();
        end
        send_item(byte_q.pop_front(), 1'b0, '0);
      end
      pkt_if.valid <= 1'b0;
    end

    drain_results();
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // run limit
  initial begin
    #1000000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

>>> pointer_packet_cursor_tracker_top.f
hdl/pct_pkg.sv
hdl/pct_stream_if.sv
hdl/pct_cfg_regs.sv
hdl/pct_decoder.sv
hdl/pct_axis.sv
hdl/pointer_packet_cursor_tracker_top.sv
tb/tb_pointer_packet_cursor_tracker_top.sv
